// ===== rtl/pc_hotspot_profiler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the PC hotspot profiler
// Shared concurrent-assertion forms, clocked on clk and gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef PC_HOTSPOT_PROFILER_ASSERT_SVH
`define PC_HOTSPOT_PROFILER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define PCHP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PCHP_ASSERT_IMPL(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) else $error(msg);

`endif

// ===== rtl/pc_hsp_pkg.sv =====
// ----------------------------------------------------------------------------
// PC hotspot profiler package
// Depths, index widths, register codes and the front-to-back item type.
// ----------------------------------------------------------------------------
`default_nettype none

package pc_hsp_pkg;

	localparam int HIST_DEPTH  = 512;
	localparam int BLOCK_DEPTH = 256;
	localparam int HIST_AW     = $clog2(HIST_DEPTH) > 0 ? $clog2(HIST_DEPTH) : 1;
	localparam int HIST_CW     = $clog2(HIST_DEPTH + 1);
	localparam int BLOCK_AW    = $clog2(BLOCK_DEPTH) > 0 ? $clog2(BLOCK_DEPTH) : 1;
	localparam int BLOCK_CW    = $clog2(BLOCK_DEPTH + 1);

	localparam logic [31:0] ADDR_MASK       = 32'hFFFF_FFFE;
	localparam logic [31:0] HITS_MAX        = 32'hFFFF_FFFF;
	localparam logic [31:0] REGION_LOW_RST  = 32'h002D_9000;
	localparam logic [31:0] REGION_HIGH_RST = 32'h002D_9800;
	localparam logic [15:0] JUMP_DIST_RST   = 16'd16;

	localparam int CFG_IW = 4;
	localparam logic [CFG_IW-1:0] REG_ARMED       = 4'd0;
	localparam logic [CFG_IW-1:0] REG_REGION_LOW  = 4'd1;
	localparam logic [CFG_IW-1:0] REG_REGION_HIGH = 4'd2;
	localparam logic [CFG_IW-1:0] REG_JUMP_DIST   = 4'd3;

	// Classified sample handed from the front to the back.
	typedef struct packed {
		logic [31:0] pc;
		logic        armed;
		logic        first;
		logic        left;
		logic        jump;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/pc_hsp_front.sv =====
// ----------------------------------------------------------------------------
// PC hotspot profiler front
// Accepts samples, flags first and band-leave events, detects far jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_hsp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        pc,
	input  wire logic               armed,
	input  wire logic [31:0]        region_low,
	input  wire logic [31:0]        region_high,
	input  wire logic [15:0]        jump_distance,
	output logic                    push,
	output pc_hsp_pkg::item_t       push_item,
	input  wire logic               q_full
);

	logic [31:0] prev_pc_q;
	logic        seen_first_q;
	logic        has_left_q;
	logic [31:0] jump_span;
	logic        outside;
	logic        far;

	assign in_ready  = !q_full;
	assign push      = in_valid && !q_full;
	assign jump_span = {16'd0, jump_distance};
	assign outside   = (pc < region_low) || (pc > region_high);
	assign far       = (pc > prev_pc_q + jump_span) || (pc + jump_span < prev_pc_q);

	always_comb begin
		push_item.pc    = pc;
		push_item.armed = armed;
		push_item.first = armed && !seen_first_q;
		push_item.left  = armed && !has_left_q && outside;
		push_item.jump  = armed && far && (prev_pc_q != 32'd0)
			&& ((pc & pc_hsp_pkg::ADDR_MASK) != (prev_pc_q & pc_hsp_pkg::ADDR_MASK));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pc_q    <= 32'd0;
			seen_first_q <= 1'b0;
			has_left_q   <= 1'b0;
		end else if (push) begin
			prev_pc_q <= pc;
			if (push_item.first) seen_first_q <= 1'b1;
			if (push_item.left)  has_left_q   <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pc_hsp_fifo.sv =====
// ----------------------------------------------------------------------------
// PC hotspot profiler item queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_hsp_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire pc_hsp_pkg::item_t  push_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    not_empty,
	output pc_hsp_pkg::item_t       head
);

	pc_hsp_pkg::item_t slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pc_hsp_back.sv =====
// ----------------------------------------------------------------------------
// PC hotspot profiler back
// Walks the histogram and block lists, updates them, registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pc_hotspot_profiler_assert.svh"

module pc_hsp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_not_empty,
	input  wire pc_hsp_pkg::item_t  q_head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    profiled,
	output logic                    first_sample,
	output logic                    left_region,
	output logic [31:0]             hit_count,
	output logic                    histogram_drop,
	output logic                    new_block,
	output logic [31:0]             hot_address,
	output logic [31:0]             hot_hits
);

	typedef enum logic [2:0] {
		S_IDLE, S_HRD, S_HCMP, S_BRD, S_BCMP, S_OUT
	} state_t;

	state_t                          state_q;
	pc_hsp_pkg::item_t               cur_q;
	logic [pc_hsp_pkg::HIST_CW-1:0]  hidx_q;
	logic [pc_hsp_pkg::HIST_CW-1:0]  hist_used_q;
	logic [pc_hsp_pkg::BLOCK_CW-1:0] bidx_q;
	logic [pc_hsp_pkg::BLOCK_CW-1:0] blk_used_q;
	logic [31:0]                     hot_addr_q;
	logic [31:0]                     hot_cnt_q;
	logic [31:0]                     hits_q;
	logic                            drop_q;
	logic                            nb_q;

	logic [31:0] hist_addr_mem [pc_hsp_pkg::HIST_DEPTH];
	logic [31:0] hist_hits_mem [pc_hsp_pkg::HIST_DEPTH];
	logic [31:0] blk_mem       [pc_hsp_pkg::BLOCK_DEPTH];
	logic [31:0] ha_rd_q;
	logic [31:0] hh_rd_q;
	logic [31:0] bk_rd_q;

	logic [31:0]                     addr;
	logic [31:0]                     inc_hits;
	logic                            h_we;
	logic [pc_hsp_pkg::HIST_AW-1:0]  h_wa;
	logic [31:0]                     h_wd_addr;
	logic [31:0]                     h_wd_hits;
	logic                            b_we;
	logic [pc_hsp_pkg::BLOCK_AW-1:0] b_wa;

	assign addr     = cur_q.pc & pc_hsp_pkg::ADDR_MASK;
	assign inc_hits = (hh_rd_q == pc_hsp_pkg::HITS_MAX) ? hh_rd_q : hh_rd_q + 32'd1;
	assign pop      = (state_q == S_IDLE) && q_not_empty;

	// Memory write ports: append or bump in the histogram, append in the block list.
	always_comb begin
		h_we      = 1'b0;
		h_wa      = hidx_q[pc_hsp_pkg::HIST_AW-1:0];
		h_wd_addr = addr;
		h_wd_hits = inc_hits;
		b_we      = 1'b0;
		b_wa      = blk_used_q[pc_hsp_pkg::BLOCK_AW-1:0];
		case (state_q)
			S_HRD: begin
				if (hidx_q >= hist_used_q && hist_used_q < pc_hsp_pkg::HIST_CW'(pc_hsp_pkg::HIST_DEPTH)) begin
					h_we      = 1'b1;
					h_wa      = hist_used_q[pc_hsp_pkg::HIST_AW-1:0];
					h_wd_hits = 32'd1;
				end
			end
			S_HCMP: begin
				if (ha_rd_q == addr) h_we = 1'b1;
			end
			S_BRD: begin
				if (bidx_q >= blk_used_q && blk_used_q < pc_hsp_pkg::BLOCK_CW'(pc_hsp_pkg::BLOCK_DEPTH))
					b_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hist_addr_mem[h_wa] <= h_wd_addr;
			hist_hits_mem[h_wa] <= h_wd_hits;
		end
		if (b_we) blk_mem[b_wa] <= addr;
		ha_rd_q <= hist_addr_mem[hidx_q[pc_hsp_pkg::HIST_AW-1:0]];
		hh_rd_q <= hist_hits_mem[hidx_q[pc_hsp_pkg::HIST_AW-1:0]];
		bk_rd_q <= blk_mem[bidx_q[pc_hsp_pkg::BLOCK_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			hidx_q      <= '0;
			bidx_q      <= '0;
			hist_used_q <= '0;
			blk_used_q  <= '0;
			hot_addr_q  <= 32'd0;
			hot_cnt_q   <= 32'd0;
			hits_q      <= 32'd0;
			drop_q      <= 1'b0;
			nb_q        <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_not_empty) begin
						cur_q  <= q_head;
						hidx_q <= '0;
						bidx_q <= '0;
						hits_q <= 32'd0;
						drop_q <= 1'b0;
						nb_q   <= 1'b0;
						state_q <= q_head.armed ? S_HRD : S_OUT;
					end
				end
				S_HRD: begin
					if (hidx_q < hist_used_q) begin
						state_q <= S_HCMP;
					end else begin
						if (h_we) begin
							hist_used_q <= hist_used_q + 1'b1;
							hits_q      <= 32'd1;
						end else begin
							drop_q <= 1'b1;
						end
						state_q <= cur_q.jump ? S_BRD : S_OUT;
					end
				end
				S_HCMP: begin
					if (ha_rd_q == addr) begin
						hits_q <= inc_hits;
						if (inc_hits > hot_cnt_q) begin
							hot_cnt_q  <= inc_hits;
							hot_addr_q <= addr;
						end
						state_q <= cur_q.jump ? S_BRD : S_OUT;
					end else begin
						hidx_q  <= hidx_q + 1'b1;
						state_q <= S_HRD;
					end
				end
				S_BRD: begin
					if (bidx_q < blk_used_q) begin
						state_q <= S_BCMP;
					end else begin
						if (b_we) begin
							blk_used_q <= blk_used_q + 1'b1;
							nb_q       <= 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_BCMP: begin
					if (bk_rd_q == addr) begin
						state_q <= S_OUT;
					end else begin
						bidx_q  <= bidx_q + 1'b1;
						state_q <= S_BRD;
					end
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = (state_q == S_OUT);
	assign profiled       = cur_q.armed;
	assign first_sample   = cur_q.first;
	assign left_region    = cur_q.left;
	assign hit_count      = hits_q;
	assign histogram_drop = drop_q;
	assign new_block      = nb_q;
	assign hot_address    = hot_addr_q;
	assign hot_hits       = hot_cnt_q;

	`PCHP_ASSERT(a_hist_bound, (hist_used_q <= pc_hsp_pkg::HIST_CW'(pc_hsp_pkg::HIST_DEPTH)), "histogram fill past depth")
	`PCHP_ASSERT_IMPL(a_hits_live, out_valid && profiled && !histogram_drop, hit_count != 32'd0, "profiled hit without count")
	`PCHP_ASSERT_IMPL(a_nb_armed, out_valid && new_block, profiled && !$past(blk_used_q == 0 && nb_q == 1'b0 && state_q == S_IDLE), "block start while disarmed")
	`PCHP_ASSERT_IMPL(a_hot_zero, hot_cnt_q == 32'd0, hot_addr_q == 32'd0, "hot address without hits")

endmodule

`default_nettype wire

// ===== rtl/pc_hotspot_profiler.sv =====
// ----------------------------------------------------------------------------
// PC hotspot profiler
// Per-sample hotspot histogram, band-leave and block-start tracking.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// in        in_valid/in_ready     pc
// out       out_valid/out_ready   profiled .. hot_hits
// cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//
// The front takes one item per cycle into a two-entry queue while the queue is not full.
// The back pops an item, walks the histogram entry by entry to a match or its
// end, then walks the block list likewise, and then holds the result; the block
// list is walked only for an armed far jump. A disarmed item skips both walks.
// Reset clears counts and flags; no memory sweep.
// A held result stalls the back only; the front fills the queue, then stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_hotspot_profiler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [31:0]                   pc,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               profiled,
	output logic                               first_sample,
	output logic                               left_region,
	output logic [31:0]                        hit_count,
	output logic                               histogram_drop,
	output logic                               new_block,
	output logic [31:0]                        hot_address,
	output logic [31:0]                        hot_hits,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pc_hsp_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);

	logic        armed_q;
	logic [31:0] region_low_q;
	logic [31:0] region_high_q;
	logic [15:0] jump_dist_q;

	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_not_empty;
	pc_hsp_pkg::item_t push_item;
	pc_hsp_pkg::item_t q_head;

	// Config always accepted; unknown indexes drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			region_low_q  <= pc_hsp_pkg::REGION_LOW_RST;
			region_high_q <= pc_hsp_pkg::REGION_HIGH_RST;
			jump_dist_q   <= pc_hsp_pkg::JUMP_DIST_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pc_hsp_pkg::REG_ARMED:       armed_q       <= cfg_data[0];
				pc_hsp_pkg::REG_REGION_LOW:  region_low_q  <= cfg_data;
				pc_hsp_pkg::REG_REGION_HIGH: region_high_q <= cfg_data;
				pc_hsp_pkg::REG_JUMP_DIST:   jump_dist_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Classify incoming samples and track the previous PC.
	pc_hsp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pc            (pc),
		.armed         (armed_q),
		.region_low    (region_low_q),
		.region_high   (region_high_q),
		.jump_distance (jump_dist_q),
		.push          (push),
		.push_item     (push_item),
		.q_full        (q_full)
	);

	// Decouple the front from the list walks.
	pc_hsp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Histogram and block-list search, update and result register.
	pc_hsp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_head         (q_head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.profiled       (profiled),
		.first_sample   (first_sample),
		.left_region    (left_region),
		.hit_count      (hit_count),
		.histogram_drop (histogram_drop),
		.new_block      (new_block),
		.hot_address    (hot_address),
		.hot_hits       (hot_hits)
	);

endmodule

`default_nettype wire
